[src/dsm_pkg.sv]
// shared types and constants for the dot-star line matcher
`timescale 1ns / 1ps

package dsm_pkg;

  // token layout inside a token word: byte in the low 8 bits, star flag on top
  typedef struct packed {
    logic       star;
    logic [7:0] chr;
  } token_t;

  localparam int unsigned TokenW        = 9;
  localparam int unsigned TokensPerWord = 7;
  localparam int unsigned NumTokenWords = 4;
  localparam int unsigned TokenWordW    = TokenW * TokensPerWord;
  localparam int unsigned LenCfgW       = 5;
  localparam int unsigned CfgIdxW       = 3;
  localparam int unsigned LineNumW      = 16;

  localparam logic [7:0]          DotByte      = 8'h2E;
  localparam logic [LineNumW-1:0] LineCountMax = '1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPatternLength = 3'd0,
    CfgTokenWord0    = 3'd1,
    CfgTokenWord1    = 3'd2,
    CfgTokenWord2    = 3'd3,
    CfgTokenWord3    = 3'd4
  } cfg_idx_e;

endpackage

[src/dsm_nfa_step.sv]
// one-byte update of the token nfa: star closure, byte consume, closure again
`timescale 1ns / 1ps

module dsm_nfa_step #(
  parameter int unsigned MaxTokens = 28
) (
  input  logic [MaxTokens:0]                  active_i,
  input  dsm_pkg::token_t [MaxTokens-1:0]     tokens_i,
  input  logic [$clog2(MaxTokens+1)-1:0]      len_i,
  input  logic [7:0]                          char_i,
  output logic [MaxTokens:0]                  active_o,
  output logic                                hit_o
);
  import dsm_pkg::*;

  localparam int unsigned N      = MaxTokens + 1;
  localparam int unsigned LenW   = $clog2(MaxTokens + 1);
  localparam int unsigned Levels = $clog2(N);

  // prefix closure: bit j is reached if set, or bit j-1 is reached and bit j passes
  function automatic logic [N-1:0] close_set(input logic [N-1:0] set,
                                             input logic [N-1:0] pass);
    logic [N-1:0] g;
    logic [N-1:0] p;
    logic [N-1:0] g_n;
    logic [N-1:0] p_n;
    int           span;
    g = set;
    p = pass;
    for (int lvl = 0; lvl < Levels; lvl++) begin
      span = 1 << lvl;
      g_n  = g;
      p_n  = p;
      for (int j = 0; j < N; j++) begin
        if (j >= span) begin
          g_n[j] = g[j] | (p[j] & g[j-span]);
          p_n[j] = p[j] & p[j-span];
        end
      end
      g = g_n;
      p = p_n;
    end
    return g;
  endfunction

  logic [MaxTokens-1:0] tok_en;
  logic [MaxTokens-1:0] tok_hit;
  logic [MaxTokens-1:0] stay;
  logic [MaxTokens-1:0] adv;
  logic [N-1:0]         pass;
  logic [N-1:0]         mask;
  logic [N-1:0]         start_set;
  logic [N-1:0]         consumed;
  logic [N-1:0]         next_set;

  always_comb begin
    pass[0] = 1'b0;
    for (int i = 0; i < MaxTokens; i++) begin
      tok_en[i]  = (LenW'(i) < len_i);
      tok_hit[i] = (tokens_i[i].chr == DotByte) || (tokens_i[i].chr == char_i);
      pass[i+1]  = tokens_i[i].star & tok_en[i];
    end
    for (int j = 0; j < N; j++) begin
      mask[j] = (LenW'(j) <= len_i);
    end
  end

  always_comb begin
    // fresh start at position 0 before every byte
    start_set = close_set((active_i & mask) | N'(1), pass);
    for (int i = 0; i < MaxTokens; i++) begin
      stay[i] = start_set[i] & tok_hit[i] & tok_en[i] & tokens_i[i].star;
      adv[i]  = start_set[i] & tok_hit[i] & tok_en[i] & ~tokens_i[i].star;
    end
    consumed = {1'b0, stay} | {adv, 1'b0};
    next_set = close_set(consumed, pass) & mask;
  end

  assign active_o = next_set;
  assign hit_o    = next_set[len_i];

endmodule

[src/dot_star_regex_line_matcher.sv]
// top level of the dot-star line matcher: stream ports, config and pipeline
`timescale 1ns / 1ps

// channel     dir  handshake               payload
// s_axis      in   s_axis_tvalid/tready    tdata: text_char, tlast: end_of_line,
//                                          tuser: empty_line
// m_axis      out  m_axis_tvalid/tready    tdata: line_number, tuser: matched
// cfg         in   cfg_we_i                cfg_idx_i, cfg_data_i
//
// one word per cycle sustained while results are taken; an input word passes the
// input register, then the nfa update into the result register
// the nfa state feeds back through the closure/consume logic
// async active-low reset clears nfa state, line count, pattern registers
// a stalled result register holds while the input register keeps filling
// until both are full; then s_axis_tready drops

module dot_star_regex_line_matcher #(
  parameter int unsigned MAX_TOKENS = 28
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config write port
  input  logic                              cfg_we_i,
  input  logic [dsm_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [dsm_pkg::TokenWordW-1:0]    cfg_data_i,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [7:0] text_char
  input  logic                              s_axis_tlast,
  input  logic                              s_axis_tuser,  // [0] empty_line
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [dsm_pkg::LineNumW-1:0]      m_axis_tdata,  // [15:0] line_number
  output logic                              m_axis_tuser   // [0] matched
);
  import dsm_pkg::*;

  localparam int unsigned LenW = $clog2(MAX_TOKENS + 1);

  // config registers
  logic [LenCfgW-1:0]    pat_len_q;
  logic [TokenWordW-1:0] tok_word_q [NumTokenWords];

  // input register
  logic       in_vld_q;
  logic       in_vld_d;
  logic [7:0] in_char_q;
  logic       in_eol_q;
  logic       in_empty_q;

  // nfa state and line count
  logic [MAX_TOKENS:0]   active_q;
  logic [MAX_TOKENS:0]   active_d;
  logic [LineNumW-1:0]   lines_q;
  logic [LineNumW-1:0]   lines_d;

  // result register
  logic                  out_vld_q;
  logic                  out_vld_d;
  logic [LineNumW-1:0]   out_line_q;
  logic                  out_match_q;

  logic                  advance;
  logic                  finish;
  logic [LenW-1:0]       len_eff;
  token_t [MAX_TOKENS-1:0] tokens;
  logic [MAX_TOKENS:0]   step_active;
  logic                  step_hit;

  // config writes; indexes past the last register are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q <= '0;
      for (int w = 0; w < NumTokenWords; w++) begin
        tok_word_q[w] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgPatternLength: pat_len_q     <= cfg_data_i[LenCfgW-1:0];
        CfgTokenWord0:    tok_word_q[0] <= cfg_data_i;
        CfgTokenWord1:    tok_word_q[1] <= cfg_data_i;
        CfgTokenWord2:    tok_word_q[2] <= cfg_data_i;
        CfgTokenWord3:    tok_word_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // unpack tokens, token k sits in word k/7 at slot k%7
  always_comb begin
    for (int k = 0; k < MAX_TOKENS; k++) begin
      tokens[k] = token_t'(tok_word_q[k / TokensPerWord][TokenW*(k % TokensPerWord) +: TokenW]);
    end
  end

  // lengths past the token capacity clamp to it
  assign len_eff = (pat_len_q > LenCfgW'(MAX_TOKENS)) ? LenW'(MAX_TOKENS)
                                                     : pat_len_q[LenW-1:0];

  dsm_nfa_step #(
    .MaxTokens(MAX_TOKENS)
  ) u_step (
    .active_i (active_q),
    .tokens_i (tokens),
    .len_i    (len_eff),
    .char_i   (in_char_q),
    .active_o (step_active),
    .hit_o    (step_hit)
  );

  // the held word moves on once the result register can take a result
  assign advance       = in_vld_q & (~out_vld_q | m_axis_tready);
  assign finish        = in_eol_q | in_empty_q;
  assign s_axis_tready = ~in_vld_q | advance;

  always_comb begin
    in_vld_d  = (s_axis_tvalid & s_axis_tready) | (in_vld_q & ~advance);
    active_d  = active_q;
    lines_d   = lines_q;
    out_vld_d = out_vld_q & ~m_axis_tready;
    if (advance) begin
      // empty line wipes the state, otherwise take the nfa update
      active_d = in_empty_q ? '0 : step_active;
      if (finish) begin
        active_d  = '0;
        out_vld_d = 1'b1;
        if (lines_q != LineCountMax) begin
          lines_d = lines_q + LineNumW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      active_q  <= '0;
      lines_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      active_q  <= active_d;
      lines_q   <= lines_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char_q  <= s_axis_tdata;
      in_eol_q   <= s_axis_tlast;
      in_empty_q <= s_axis_tuser;
    end
    if (advance && finish) begin
      out_line_q  <= lines_d;
      out_match_q <= ~in_empty_q & step_hit;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_line_q;
  assign m_axis_tuser  = out_match_q;

endmodule

[tb/dot_star_regex_line_matcher_tb.sv]
// self-checking testbench for the dot-star line matcher
`timescale 1ns / 1ps

module dot_star_regex_line_matcher_tb;
  import dsm_pkg::*;

  localparam int MaxTok     = 28;
  localparam int CycleLimit = 600_000;
  localparam int SettleGap  = 4;   // pipe drain plus margin
  localparam int SegWords   = 30;  // words per random config setting
  localparam int SegsPerMode = 6;

  // kinds of row in the directed table
  typedef enum logic {
    RowWord,
    RowCfg
  } row_kind_e;

  typedef struct packed {
    row_kind_e              kind;
    cfg_idx_e               idx;
    logic [TokenWordW-1:0]  data;
    logic [7:0]             chr;
    logic                   eol;
    logic                   empty;
    logic                   typed;        // expected flag typed into the row
    logic                   typed_match;
  } dir_row_t;

  typedef struct packed {
    logic [LineNumW-1:0] line;
    logic                matched;
  } line_result_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxW-1:0]     cfg_idx_i;
  logic [TokenWordW-1:0]  cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata;   // [7:0] text_char
  logic                   s_axis_tlast;
  logic                   s_axis_tuser;   // [0] empty_line
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [LineNumW-1:0]    m_axis_tdata;   // [15:0] line_number
  logic                   m_axis_tuser;   // [0] matched

  dot_star_regex_line_matcher #(
    .MAX_TOKENS(MaxTok)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // matcher shadow state, updated at each accepted word or config write
  logic [LenCfgW-1:0]    pat_len;
  logic [TokenWordW-1:0] tok_words [NumTokenWords];
  logic [MaxTok:0]       nfa_set;
  logic [LineNumW-1:0]   line_cnt;

  line_result_t line_results_due [$];
  dir_row_t     dir_rows [$];

  int send_idle_pct;
  int recv_idle_pct;
  int fail_cnt;
  int cycle_cnt;

  // ---------------------------------------------------------------------------
  // line matcher prediction
  // ---------------------------------------------------------------------------

  function automatic token_t token_at(int k);
    return token_t'(tok_words[k / TokensPerWord][TokenW * (k % TokensPerWord) +: TokenW]);
  endfunction

  // a starred token may be skipped, so an active position also activates the next one
  function automatic logic [MaxTok:0] skip_stars(logic [MaxTok:0] s, int n);
    for (int i = 0; i < n; i++) begin
      if (s[i] && token_at(i).star) s[i + 1] = 1'b1;
    end
    return s;
  endfunction

  // advances the shadow nfa by one word; returns 1 when the word ends a line
  function automatic bit predict_word(input logic [7:0] chr, input logic eol,
                                      input logic empty, output line_result_t res);
    int              n;
    logic [31:0]     mask32;
    logic [MaxTok:0] mask;
    logic [MaxTok:0] cur;
    logic [MaxTok:0] nxt;
    token_t          t;
    logic            hit;
    n      = (int'(pat_len) > MaxTok) ? MaxTok : int'(pat_len);
    mask32 = (32'd1 << (n + 1)) - 32'd1;
    mask   = mask32[MaxTok:0];
    res    = '0;
    if (empty) begin
      hit = 1'b0;
    end else begin
      // fresh start at position 0 before every byte, stale high positions dropped
      cur = skip_stars((nfa_set & mask) | {{MaxTok{1'b0}}, 1'b1}, n);
      nxt = '0;
      for (int i = 0; i < n; i++) begin
        t = token_at(i);
        if (cur[i] && (t.chr == DotByte || t.chr == chr)) begin
          if (t.star) nxt[i] = 1'b1;
          else nxt[i + 1] = 1'b1;
        end
      end
      nfa_set = skip_stars(nxt, n) & mask;
      if (!eol) return 1'b0;
      hit = nfa_set[n];
    end
    if (line_cnt != LineCountMax) line_cnt++;
    nfa_set     = '0;
    res.line    = line_cnt;
    res.matched = hit;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one config write, predictor updated alongside; block must be idle
  task automatic cfg_write(cfg_idx_e idx, logic [TokenWordW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx == CfgPatternLength) pat_len = data[LenCfgW-1:0];
    else tok_words[int'(idx) - int'(CfgTokenWord0)] = data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // offers one word with random sender gaps, waits for the handshake
  task automatic send_word(logic [7:0] chr, logic eol, logic empty,
                           logic typed, logic typed_match);
    line_result_t res;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= chr;
    s_axis_tlast  <= eol;
    s_axis_tuser  <= empty;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (predict_word(chr, eol, empty, res)) begin
      if (typed) res.matched = typed_match;
      line_results_due = {line_results_due, res};
    end
  endtask

  // sender holds off until every pending line result has been taken
  task automatic settle_results(int extra);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (line_results_due.size() != 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  // pattern bytes lean on a small alphabet and the dot so that matches are common
  function automatic logic [7:0] pick_pattern_byte();
    case ($urandom_range(0, 9))
      0, 1, 2: return "a";
      3, 4:    return "b";
      5:       return "c";
      6, 7, 8: return DotByte;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_text_byte();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return "a";
      4, 5, 6:    return "b";
      7, 8:       return "c";
      default:    return 8'($urandom);
    endcase
  endfunction

  task automatic load_random_pattern();
    logic [TokenWordW-1:0] word;
    int                    sel;
    for (int w = 0; w < NumTokenWords; w++) begin
      word = TokenWordW'({$urandom, $urandom});
      // mostly well-formed tokens, now and then a fully random word
      if ($urandom_range(0, 7) != 0) begin
        for (int k = 0; k < TokensPerWord; k++)
          word[TokenW * k +: TokenW] = {($urandom_range(0, 9) < 3), pick_pattern_byte()};
      end
      cfg_write(cfg_idx_e'(int'(CfgTokenWord0) + w), word);
    end
    sel = $urandom_range(0, 15);
    case (sel)
      0:       cfg_write(CfgPatternLength, '0);
      1:       cfg_write(CfgPatternLength, TokenWordW'(MaxTok));
      2:       cfg_write(CfgPatternLength,
                         TokenWordW'($urandom_range(MaxTok + 1, (1 << LenCfgW) - 1)));
      default: cfg_write(CfgPatternLength, TokenWordW'($urandom_range(1, 6)));
    endcase
  endtask

  // short lines of random content, some empty lines; the last line may be cut
  task automatic send_random_lines(int count);
    int sent;
    int len;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 11) == 0) begin
        send_word(8'($urandom), 1'($urandom), 1'b1, 1'b0, 1'b0);
        sent++;
      end else begin
        len = $urandom_range(1, 10);
        for (int j = 0; j < len && sent < count; j++) begin
          send_word(pick_text_byte(), j == len - 1, 1'b0, 1'b0, 1'b0);
          sent++;
        end
        if ($urandom_range(0, 24) == 0) settle_results(0);
      end
    end
  endtask

  function automatic dir_row_t word_row(logic [7:0] chr, logic eol, logic empty,
                                        logic typed, logic typed_match);
    return '{RowWord, CfgPatternLength, '0, chr, eol, empty, typed, typed_match};
  endfunction

  function automatic dir_row_t cfg_row(cfg_idx_e idx, logic [TokenWordW-1:0] data);
    return '{RowCfg, idx, data, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0};
  endfunction

  function automatic void add_row(dir_row_t row);
    dir_rows = {dir_rows, row};
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, int unsigned want_v, int unsigned got_v);
    fail_cnt++;
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
  endtask

  // every result word against the oldest pending line result
  always @(posedge clk_i) begin : result_mon
    line_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (line_results_due.size() == 0) begin
        fail_cnt++;
        $display("%0t ns: result word with none pending, expected none, actual line %0d %0d",
                 $time, m_axis_tdata, m_axis_tuser);
      end else begin
        want = line_results_due.pop_front();
        if (m_axis_tdata !== want.line)
          report_mismatch("line_number", want.line, m_axis_tdata);
        if (m_axis_tuser !== want.matched)
          report_mismatch("matched", want.matched, m_axis_tuser);
      end
    end
  end

  // receiver stalls at random per the current mode
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // run guard
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgPatternLength;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    send_idle_pct = 20;
    recv_idle_pct = 82;
    fail_cnt      = 0;
    cycle_cnt     = 0;
    pat_len       = '0;
    nfa_set       = '0;
    line_cnt      = '0;
    for (int w = 0; w < NumTokenWords; w++) tok_words[w] = '0;

    // directed table
    // empty pattern after reset never matches
    add_row(word_row("a", 1'b1, 1'b0, 1'b1, 1'b0));
    // empty line with its byte and last flag set, both ignored
    add_row(word_row(8'hFF, 1'b1, 1'b1, 1'b1, 1'b0));
    // pattern a*b
    add_row(cfg_row(CfgTokenWord0, TokenWordW'({1'b0, 8'("b"), 1'b1, 8'("a")})));
    add_row(cfg_row(CfgPatternLength, TokenWordW'(2)));
    add_row(word_row("b", 1'b1, 1'b0, 1'b0, 1'b0));
    add_row(word_row("x", 1'b0, 1'b0, 1'b0, 1'b0));
    add_row(word_row("a", 1'b0, 1'b0, 1'b0, 1'b0));
    add_row(word_row("a", 1'b0, 1'b0, 1'b0, 1'b0));
    add_row(word_row("b", 1'b1, 1'b0, 1'b0, 1'b0));
    add_row(word_row("b", 1'b0, 1'b0, 1'b0, 1'b0));
    add_row(word_row("x", 1'b1, 1'b0, 1'b0, 1'b0));
    // pattern .* takes any non-empty suffix, byte extremes
    add_row(cfg_row(CfgTokenWord0, TokenWordW'({1'b1, DotByte})));
    add_row(cfg_row(CfgPatternLength, TokenWordW'(1)));
    add_row(word_row(8'h00, 1'b1, 1'b0, 1'b0, 1'b0));
    add_row(word_row(8'hFF, 1'b1, 1'b0, 1'b0, 1'b0));
    add_row(word_row(8'h00, 1'b0, 1'b1, 1'b1, 1'b0));
    // all-ones token words, length beyond the token count
    add_row(cfg_row(CfgTokenWord0, '1));
    add_row(cfg_row(CfgTokenWord1, '1));
    add_row(cfg_row(CfgTokenWord2, '1));
    add_row(cfg_row(CfgTokenWord3, '1));
    add_row(cfg_row(CfgPatternLength, TokenWordW'((1 << LenCfgW) - 1)));
    add_row(word_row(8'hFF, 1'b1, 1'b0, 1'b0, 1'b0));
    add_row(word_row(8'h00, 1'b1, 1'b0, 1'b0, 1'b0));
    add_row(word_row(8'hFF, 1'b0, 1'b0, 1'b0, 1'b0));
    // pattern emptied in the middle of a line
    add_row(cfg_row(CfgPatternLength, '0));
    add_row(word_row(8'hFF, 1'b1, 1'b0, 1'b1, 1'b0));
    // full token count
    add_row(cfg_row(CfgPatternLength, TokenWordW'(MaxTok)));
    add_row(word_row(8'hFF, 1'b1, 1'b0, 1'b0, 1'b0));
    // pattern a.c with a plain dot
    add_row(cfg_row(CfgTokenWord0,
                    TokenWordW'({1'b0, 8'("c"), 1'b0, DotByte, 1'b0, 8'("a")})));
    add_row(cfg_row(CfgPatternLength, TokenWordW'(3)));
    add_row(word_row("a", 1'b0, 1'b0, 1'b0, 1'b0));
    add_row(word_row("q", 1'b0, 1'b0, 1'b0, 1'b0));
    add_row(word_row("c", 1'b1, 1'b0, 1'b0, 1'b0));

    // single reset at the start
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == RowCfg) begin
        settle_results(SettleGap);
        cfg_write(dir_rows[r].idx, dir_rows[r].data);
      end else begin
        send_word(dir_rows[r].chr, dir_rows[r].eol, dir_rows[r].empty,
                  dir_rows[r].typed, dir_rows[r].typed_match);
      end
    end

    // random part: sender-light, receiver-light, then no idling at all
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 20;
          recv_idle_pct = 82;
        end
        1: begin
          send_idle_pct = 82;
          recv_idle_pct = 20;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < SegsPerMode; seg++) begin
        settle_results(SettleGap);
        load_random_pattern();
        send_random_lines(SegWords);
      end
    end

    settle_results(2 * SettleGap);
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
